[design/shrp_pkg.sv]
// Shared types and constants for the 3x3 sharpen filter.
package shrp_pkg;

    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 13;
    localparam int MAX_HEIGHT = 4096;
    localparam int USER_W     = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 8'd0,
        REG_IMAGE_HEIGHT = 8'd1
    } cfg_reg_t;

    // Line store control from the top level.
    typedef struct packed {
        logic rd_en;   // read both lines at rd_addr
        logic wr_en;   // shift the column up at wr_addr
    } line_ctl_t;

endpackage

[design/sharpen_filter_3x3_core.sv]
// Top level of the streaming 3x3 Laplacian sharpen filter.
//
// Input: a padded 8-bit gray frame, (image_width+2) x (image_height+2) pixels,
// in raster order, one word per s_tvalid/s_tready handshake.
// Output: one word per interior pixel, 5*center - N - S - W - E clamped to
// 0..255, on m_tdata; m_tuser[0] flags the last word of an output row and
// m_tlast the last word of the frame.
// Config: cfg_valid/cfg_ready writes image_width (index 0) or image_height
// (index 1); either write restarts the frame position. Write only when idle.
// Widths out of range saturate to 1..MAX_WIDTH, heights to 1..4096.
// Throughput: one pixel per clock while the output is not stalled. A pixel is
// registered in stage A (line store read register), then in the result reg.
// Each pixel takes one line store read and one line store write.
// Reset (aresetn low, synchronous) empties both stages, zeroes the window and
// the position counters and loads 256x256; line stores are not cleared.
// When m_tready is low the result register holds; the staged pixel waits
// behind it and s_tready drops only once both are full.
module sharpen_filter_3x3_core
    import shrp_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input pixels
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,    // [7:0] pixel_in
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIX_W-1:0]      m_tdata,    // [7:0] pixel_out
    output logic [USER_W-1:0]     m_tuser,    // [0] row_end, [1] unused (0)
    output logic                  m_tlast,    // frame_end
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_WIDTH + 2;
    localparam int COL_W = $clog2(DEPTH);
    localparam int XW    = (COL_W > WIDTH_W) ? COL_W : WIDTH_W;

    // config
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                cfg_we;

    // position of the next padded pixel
    logic [COL_W-1:0]    col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic [COL_W-1:0]    last_col;
    logic [HEIGHT_W-1:0] last_row;
    logic [XW-1:0]       width_x;
    logic [COL_W-1:0]    width_sat;
    logic [HEIGHT_W-1:0] height_sat;

    // stage A: accepted pixel, line store read in flight
    logic                a_valid_reg;
    logic [PIX_W-1:0]    a_pix_reg;
    logic [COL_W-1:0]    a_col_reg;
    logic                a_emit_reg;
    logic                a_row_end_reg;
    logic                a_frame_end_reg;

    // window: only the taps the kernel needs
    logic [PIX_W-1:0]    win_top_reg;   // upper row, newest column
    logic [PIX_W-1:0]    win_mid0_reg;  // middle row, column left of center
    logic [PIX_W-1:0]    win_mid1_reg;  // middle row, center column
    logic [PIX_W-1:0]    win_bot_reg;   // lower row, center column

    // result register
    logic                m_valid_reg;
    logic [PIX_W-1:0]    m_pix_reg;
    logic                m_row_end_reg;
    logic                m_frame_end_reg;

    logic                advance, s_accept, a_retire;
    line_ctl_t           line_ctl;
    logic [PIX_W-1:0]    upper_rd, middle_rd;

    logic [10:0]         center5;
    logic [11:0]         neigh_sum;
    logic [11:0]         diff;
    logic [PIX_W-1:0]    pix_clamped;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_W'(256);
            height_reg <= HEIGHT_W'(256);
        end else if (cfg_we) begin
            if (cfg_index == REG_IMAGE_WIDTH) begin
                width_reg <= cfg_data[WIDTH_W-1:0];
            end
            if (cfg_index == REG_IMAGE_HEIGHT) begin
                height_reg <= cfg_data;
            end
        end
    end

    // saturated geometry; last index = size + 1 in the padded frame
    always_comb begin
        width_x = XW'(width_reg);
        if (width_reg == '0) begin
            width_sat = COL_W'(1);
        end else if (width_x > XW'(MAX_WIDTH)) begin
            width_sat = COL_W'(MAX_WIDTH);
        end else begin
            width_sat = COL_W'(width_x);
        end
        if (height_reg == '0) begin
            height_sat = HEIGHT_W'(1);
        end else if (height_reg > HEIGHT_W'(MAX_HEIGHT)) begin
            height_sat = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            height_sat = height_reg;
        end
        last_col = width_sat + COL_W'(1);
        last_row = height_sat + HEIGHT_W'(1);
    end

    // handshake
    assign advance  = !m_valid_reg || m_tready;
    assign a_retire = a_valid_reg && advance;
    assign s_tready = !a_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_accept) begin
            if (col_reg == last_col) begin
                col_next = '0;
                row_next = (row_reg == last_row) ? '0 : row_reg + HEIGHT_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cfg_we && (cfg_index == REG_IMAGE_WIDTH ||
                                cfg_index == REG_IMAGE_HEIGHT)) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage A
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_accept) begin
            a_valid_reg <= 1'b1;
        end else if (a_retire) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_pix_reg       <= s_tdata;
            a_col_reg       <= col_reg;
            a_emit_reg      <= (row_reg >= HEIGHT_W'(2)) && (col_reg >= COL_W'(2));
            a_row_end_reg   <= (col_reg == last_col);
            a_frame_end_reg <= (col_reg == last_col) && (row_reg == last_row);
        end
    end

    assign line_ctl.rd_en = s_accept;
    assign line_ctl.wr_en = a_retire;

    shrp_line_buf #(
        .DEPTH (DEPTH),
        .AW    (COL_W)
    ) u_line_buf (
        .aclk      (aclk),
        .ctl       (line_ctl),
        .rd_addr   (col_reg),
        .wr_addr   (a_col_reg),
        .wr_pix    (a_pix_reg),
        .upper_rd  (upper_rd),
        .middle_rd (middle_rd)
    );

    // kernel on the window after this column shifts in:
    // N = top tap, W = mid0, C = mid1, E = incoming middle, S = bottom tap
    always_comb begin
        center5   = {1'b0, win_mid1_reg, 2'b00} + 11'(win_mid1_reg);
        neigh_sum = 12'(win_top_reg) + 12'(win_mid0_reg)
                  + 12'(middle_rd) + 12'(win_bot_reg);
        diff      = {1'b0, center5} - neigh_sum;
        if (diff[11]) begin
            pix_clamped = '0;
        end else if (diff[10:8] != 3'b000) begin
            pix_clamped = '1;
        end else begin
            pix_clamped = diff[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_top_reg  <= '0;
            win_mid0_reg <= '0;
            win_mid1_reg <= '0;
            win_bot_reg  <= '0;
        end else if (a_retire) begin
            win_top_reg  <= upper_rd;
            win_mid0_reg <= win_mid1_reg;
            win_mid1_reg <= middle_rd;
            win_bot_reg  <= a_pix_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= a_valid_reg && a_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_retire && a_emit_reg) begin
            m_pix_reg       <= pix_clamped;
            m_row_end_reg   <= a_row_end_reg;
            m_frame_end_reg <= a_frame_end_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pix_reg;
    assign m_tuser  = {1'b0, m_row_end_reg};
    assign m_tlast  = m_frame_end_reg;

endmodule

[design/shrp_line_buf.sv]
// Two line stores (rows r-2 and r-1) with registered reads.
module shrp_line_buf
    import shrp_pkg::*;
#(
    parameter int DEPTH = 1026,
    parameter int AW    = 11
) (
    input  logic             aclk,
    input  line_ctl_t        ctl,
    input  logic [AW-1:0]    rd_addr,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PIX_W-1:0] wr_pix,
    output logic [PIX_W-1:0] upper_rd,
    output logic [PIX_W-1:0] middle_rd
);

    logic [PIX_W-1:0] upper_mem  [DEPTH];
    logic [PIX_W-1:0] middle_mem [DEPTH];
    logic [PIX_W-1:0] upper_rd_reg;
    logic [PIX_W-1:0] middle_rd_reg;

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            upper_rd_reg  <= upper_mem[rd_addr];
            middle_rd_reg <= middle_mem[rd_addr];
        end
    end

    // middle row moves up, new pixel takes its place
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            upper_mem[wr_addr]  <= middle_rd_reg;
            middle_mem[wr_addr] <= wr_pix;
        end
    end

    assign upper_rd  = upper_rd_reg;
    assign middle_rd = middle_rd_reg;

endmodule

[design/shrp_checker.sv]
// Port-level assertions for the sharpen filter, bound to the top level.
module shrp_checker
    import shrp_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [PIX_W-1:0]  m_tdata,
    input logic [USER_W-1:0] m_tuser,
    input logic              m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // frame end always closes a row
    a_frame_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("frame end without row end");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a fresh result traces back to an accepted pixel through stage A and the result register
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without accepted pixel");

endmodule

bind sharpen_filter_3x3_core shrp_checker u_shrp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
